/* hdl/kow_pkg.sv */
// ----------------------------------------------------------------------------
// kow_pkg
// Shared types and codes for the keyed ordered waitlist.
// ----------------------------------------------------------------------------
package kow_pkg;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LIST   = 2'd2;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_REMOVED   = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_LIST      = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] key;
      logic [7:0]  party_size;
   } req_type;

endpackage

/* hdl/kow_front.sv */
// ----------------------------------------------------------------------------
// kow_front
// Accepts requests, drops unused command codes, and queues the rest.
// ----------------------------------------------------------------------------
module kow_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kow_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output kow_pkg::req_type q_data
);

   kow_pkg::req_type slot_ff [2];
   logic [1:0]       cnt_ff;
   logic             rd_ff;
   logic             wr_ff;
   logic             push;
   logic             pop;
   logic             legal;

   assign legal     = (req_data.cmd == kow_pkg::CMD_ADD) ||
                      (req_data.cmd == kow_pkg::CMD_REMOVE) ||
                      (req_data.cmd == kow_pkg::CMD_LIST);
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready && legal;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = slot_ff[rd_ff];
   assign pop       = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) begin
            slot_ff[wr_ff] <= req_data;
            wr_ff <= ~wr_ff;
         end
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* hdl/kow_back.sv */
// ----------------------------------------------------------------------------
// kow_back
// Shift-register table with per-cell compare; executes queued requests.
// ----------------------------------------------------------------------------
module kow_back #(
   parameter int DEPTH     = 32,
   parameter int KEY_BITS  = 64,
   parameter int SIZE_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  kow_pkg::req_type q_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [63:0]      rsp_entry_key,
   output logic [7:0]       rsp_entry_size,
   output logic             rsp_valid_entry,
   output logic [5:0]       rsp_occupancy,
   output logic             rsp_last
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

   logic [KEY_BITS-1:0]  key_ff  [DEPTH];
   logic [SIZE_BITS-1:0] size_ff [DEPTH];
   logic [CW-1:0]        count_ff;
   logic [IW-1:0]        idx_ff;
   state_type            state_ff;

   logic [KEY_BITS-1:0]  k;
   logic [SIZE_BITS-1:0] s;
   logic [DEPTH-1:0]     live, khit, shit, first, below;
   logic                 dup, found, full, can_out, go, load;
   logic [IW-1:0]        fidx;

   logic                 do_add, do_remove;
   state_type            state_in;
   logic [IW-1:0]        idx_in;
   logic [2:0]           status_in;
   logic [63:0]          ekey_in;
   logic [7:0]           esize_in;
   logic                 vld_in;
   logic [5:0]           occ_in;
   logic                 last_in;

   assign k    = q_data.key[KEY_BITS-1:0];
   assign s    = q_data.party_size[SIZE_BITS-1:0];
   assign full = (count_ff == CW'(DEPTH));

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = (CW'(i) < count_ff);
         khit[i] = live[i] && (key_ff[i] == k);
         shit[i] = live[i] && (size_ff[i] == s);
      end
      below[0] = 1'b0;
      for (int i = 1; i < DEPTH; i++) below[i] = below[i-1] | shit[i-1];
      first = shit & ~below;
      fidx  = '0;
      for (int i = 0; i < DEPTH; i++) if (first[i]) fidx = IW'(i);
   end
   assign dup   = |khit;
   assign found = |shit;

   assign can_out = !rsp_valid || rsp_ready;
   assign q_ready = (state_ff == S_IDLE) && can_out;
   assign go      = q_valid && q_ready;
   assign load    = go || ((state_ff == S_LIST) && can_out);

   always_comb begin
      do_add    = 1'b0;
      do_remove = 1'b0;
      state_in  = state_ff;
      idx_in    = idx_ff;
      status_in = kow_pkg::ST_LIST;
      ekey_in   = '0;
      esize_in  = '0;
      vld_in    = 1'b0;
      occ_in    = 6'(count_ff);
      last_in   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            case (q_data.cmd)
               kow_pkg::CMD_ADD: begin
                  if (dup) status_in = kow_pkg::ST_DUPLICATE;
                  else if (full) status_in = kow_pkg::ST_FULL;
                  else begin
                     status_in = kow_pkg::ST_ADDED;
                     do_add    = go;
                     occ_in    = 6'(count_ff + 1'b1);
                  end
               end
               kow_pkg::CMD_REMOVE: begin
                  if (found) begin
                     status_in = kow_pkg::ST_REMOVED;
                     ekey_in   = 64'(key_ff[fidx]);
                     esize_in  = 8'(size_ff[fidx]);
                     vld_in    = 1'b1;
                     do_remove = go;
                     occ_in    = 6'(count_ff - 1'b1);
                  end else status_in = kow_pkg::ST_NOT_FOUND;
               end
               default: begin
                  status_in = kow_pkg::ST_LIST;
                  if (count_ff != '0) begin
                     ekey_in  = 64'(key_ff[0]);
                     esize_in = 8'(size_ff[0]);
                     vld_in   = 1'b1;
                     last_in  = (count_ff == CW'(1));
                     if (go) begin
                        idx_in = IW'(1 % DEPTH);
                        if (count_ff != CW'(1)) state_in = S_LIST;
                     end
                  end
               end
            endcase
         end
         S_LIST: begin
            ekey_in  = 64'(key_ff[idx_ff]);
            esize_in = 8'(size_ff[idx_ff]);
            vld_in   = 1'b1;
            last_in  = (CW'(idx_ff) + 1'b1 == count_ff);
            if (can_out) begin
               idx_in = idx_ff + 1'b1;
               if (last_in) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (load) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
         if (load) begin
            rsp_status      <= status_in;
            rsp_entry_key   <= ekey_in;
            rsp_entry_size  <= esize_in;
            rsp_valid_entry <= vld_in;
            rsp_occupancy   <= occ_in;
            rsp_last        <= last_in;
         end
         if (do_add) begin
            key_ff[count_ff[IW-1:0]]  <= k;
            size_ff[count_ff[IW-1:0]] <= s;
            count_ff <= count_ff + 1'b1;
         end
         if (do_remove) begin
            for (int i = 0; i < DEPTH - 1; i++)
               if (below[i+1] || first[i]) begin
                  key_ff[i]  <= key_ff[i+1];
                  size_ff[i] <= size_ff[i+1];
               end
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* hdl/keyed_ordered_waitlist.sv */
// ----------------------------------------------------------------------------
// keyed_ordered_waitlist
// Ordered keyed table with add, remove-by-size and list.
// ----------------------------------------------------------------------------
// Requests enter on req_ (cmd, key, party_size) with valid/ready; results
// leave on rsp_ with valid/ready. A two-entry queue sits between the front,
// which accepts requests and drops unused command codes, and the back, which
// holds the table as a row of shift cells with a compare in each cell.
// Add and remove compare all cells at once; each request passes through the
// queue and then the result register before its result is valid. A list gives
// one result per live entry, one per cycle while rsp_ready is high, or one
// empty status, with last set on the final result.
// Sustained rate: one add or remove every cycle while rsp_ready is high;
// a list holds the back until its last entry enters the result register.
// When the receiver stalls, the result register holds and the queue fills;
// req_ready falls once the queue is full. Reset empties the table and queue.
// ----------------------------------------------------------------------------
module keyed_ordered_waitlist #(
   parameter int DEPTH     = 32,
   parameter int KEY_BITS  = 64,
   parameter int SIZE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_key,
   input  logic [7:0]  req_party_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_entry_key,
   output logic [7:0]  rsp_entry_size,
   output logic        rsp_valid_entry,
   output logic [5:0]  rsp_occupancy,
   output logic        rsp_last
);

   kow_pkg::req_type req_data, q_data;
   logic             q_valid, q_ready;

   assign req_data.cmd        = req_cmd;
   assign req_data.key        = req_key;
   assign req_data.party_size = req_party_size;

   kow_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   kow_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .SIZE_BITS(SIZE_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_entry_key, .rsp_entry_size,
      .rsp_valid_entry, .rsp_occupancy, .rsp_last
   );

endmodule
